@@ rtl/core/tmp_pkg.sv @@
// ----------------------------------------------------------------------------
// Trapezoidal motion profile package
// Shared constants, register indexes and the divider/square root request type.
// ----------------------------------------------------------------------------
package tmp_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VELOCITY     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ACCELERATION = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_PERIOD      = 2'd2;

  localparam int TICK_PERIOD_RESET = 655;

  localparam logic OP_SET_TARGET = 1'b0;
  localparam logic OP_TICK       = 1'b1;

  // Request to the shared divide / square root unit.
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } ds_req_t;

endpackage

@@ rtl/core/trapezoidal_motion_profile.sv @@
// ----------------------------------------------------------------------------
// Trapezoidal motion profile generator
// Plans a velocity-matched trapezoidal or triangular move and reports the
// pose at the elapsed time on every request.
// ----------------------------------------------------------------------------
// A set-target request plans a move from a start position and velocity to a
// goal position and velocity under the max_velocity and max_acceleration
// limits, and answers with the pose at time zero; a tick request advances the
// elapsed time by tick_period and answers with the pose in the active phase.
// All values are signed fixed point with FRAC_BITS fraction bits and saturate.
// The block works on one request at a time and holds in_stall high while it
// is busy. A tick is paced by three passes through the shared multiplier. A
// set target is paced by the shared divide / square root unit, and a plan
// uses up to three divisions plus a fourth division or a square root. A
// rejected target skips the planning steps. A finished result sits in an
// output register, so the next request can be accepted while it waits to be
// taken. Configuration writes are always ready and should be issued only
// while the block is idle.
// ----------------------------------------------------------------------------
module trapezoidal_motion_profile #(
  parameter int WORD_BITS = tmp_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = tmp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Request channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               op,
  input  logic signed [WORD_BITS-1:0]        start_pos,
  input  logic signed [WORD_BITS-1:0]        start_vel,
  input  logic signed [WORD_BITS-1:0]        goal_pos,
  input  logic signed [WORD_BITS-1:0]        goal_vel,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [WORD_BITS-1:0]        pose_pos,
  output logic signed [WORD_BITS-1:0]        pose_vel,
  output logic signed [WORD_BITS-1:0]        pose_acc,
  output logic                               finished,
  output logic                               accepted,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]               cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS + 2;  // product and divider word
  localparam int XW = 2 * WORD_BITS + 4;  // wide intermediate sums

  localparam logic signed [W-1:0]  VMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  VMIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] VMAX_X  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN_X  = ~VMAX_X;
  localparam logic signed [XW-1:0] ONE_X   = {{(XW-1){1'b0}}, 1'b1};
  localparam logic signed [PW-1:0] FMASK_P = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  // Sequencer codes.
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHECK = 5'd1;
  localparam logic [4:0] S_TV    = 5'd2;
  localparam logic [4:0] S_TV_W  = 5'd3;
  localparam logic [4:0] S_XV_M  = 5'd4;
  localparam logic [4:0] S_XV    = 5'd5;
  localparam logic [4:0] S_XT    = 5'd6;
  localparam logic [4:0] S_SIGN  = 5'd7;
  localparam logic [4:0] S_VV_M  = 5'd8;
  localparam logic [4:0] S_VV    = 5'd9;
  localparam logic [4:0] S_LL_M  = 5'd10;
  localparam logic [4:0] S_LL    = 5'd11;
  localparam logic [4:0] S_XA_W  = 5'd12;
  localparam logic [4:0] S_CM    = 5'd13;
  localparam logic [4:0] S_TC_W  = 5'd14;
  localparam logic [4:0] S_AX_M  = 5'd15;
  localparam logic [4:0] S_AX    = 5'd16;
  localparam logic [4:0] S_SQ_W  = 5'd17;
  localparam logic [4:0] S_TA    = 5'd18;
  localparam logic [4:0] S_TA_W  = 5'd19;
  localparam logic [4:0] S_AT    = 5'd20;
  localparam logic [4:0] S_RP_M  = 5'd21;
  localparam logic [4:0] S_RP    = 5'd22;
  localparam logic [4:0] S_CP_M  = 5'd23;
  localparam logic [4:0] S_CP    = 5'd24;
  localparam logic [4:0] S_SEG   = 5'd25;
  localparam logic [4:0] S_AV_M  = 5'd26;
  localparam logic [4:0] S_AV    = 5'd27;
  localparam logic [4:0] S_VD_M  = 5'd28;
  localparam logic [4:0] S_VD    = 5'd29;
  localparam logic [4:0] S_AD_M  = 5'd30;
  localparam logic [4:0] S_AD    = 5'd31;

  // Sign-extend a word into the wide intermediate format.
  function automatic logic signed [XW-1:0] wx(input logic signed [W-1:0] x);
    return {{(XW-W){x[W-1]}}, x};
  endfunction

  // Sign-extend a word by one bit for the multiplier.
  function automatic logic signed [W:0] e1(input logic signed [W-1:0] x);
    return {x[W-1], x};
  endfunction

  function automatic logic signed [XW-1:0] abs_x(input logic signed [XW-1:0] x);
    return (x < 0) ? -x : x;
  endfunction

  // Saturate to the signed word range.
  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
    logic signed [W-1:0] r;
    if (x > VMAX_X) r = VMAX;
    else if (x < VMIN_X) r = VMIN;
    else r = x[W-1:0];
    return r;
  endfunction

  // Saturate to the time range, zero up to the largest word value.
  function automatic logic signed [W-1:0] sat_t(input logic signed [XW-1:0] x);
    logic signed [W-1:0] r;
    if (x > VMAX_X) r = VMAX;
    else if (x < 0) r = '0;
    else r = x[W-1:0];
    return r;
  endfunction

  // Fixed-point product scaled back by the fraction bits, rounded toward zero.
  function automatic logic signed [W-1:0] mulq(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] adj;
    logic signed [PW-1:0] sh;
    adj = p[PW-1] ? p + FMASK_P : p;
    sh  = adj >>> FRAC_BITS;
    return sat_w({{(XW-PW){sh[PW-1]}}, sh});
  endfunction

  // Unsigned quotient or root clamped to the largest word value.
  function automatic logic signed [W-1:0] satq(input logic [PW-1:0] q);
    return (|q[PW-1:W-1]) ? VMAX : {1'b0, q[W-2:0]};
  endfunction

  // Half of a sum, rounded toward zero.
  function automatic logic signed [W-1:0] half_sum(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
    logic signed [XW-1:0] s;
    s = wx(a) + wx(b);
    if (s < 0) s = s + ONE_X;
    s = s >>> 1;
    return s[W-1:0];
  endfunction

  // Configuration registers.
  logic [W-2:0]         max_velocity;
  logic [W-2:0]         max_acceleration;
  logic [FRAC_BITS-1:0] tick_period;

  // Profile state.
  logic [4:0]          state;
  logic signed [W-1:0] elapsed_time;
  logic signed [W-1:0] origin_pose_pos;
  logic signed [W-1:0] origin_pose_vel;
  logic signed [W-1:0] ramp_accel;
  logic signed [W-1:0] end_pose_pos;
  logic signed [W-1:0] end_pose_vel;
  logic signed [W-1:0] ramp_end_pos;
  logic signed [W-1:0] cruise_vel;
  logic signed [W-1:0] coast_end_pos;
  logic signed [W-1:0] ramp_end_time;
  logic signed [W-1:0] coast_end_time;
  logic signed [W-1:0] profile_end_time;

  // Planning scratch registers.
  logic signed [W-1:0] pi_r;
  logic signed [W-1:0] vi_r;
  logic signed [W-1:0] pf_r;
  logic signed [W-1:0] vf_r;
  logic signed [W-1:0] dv;
  logic signed [W-1:0] tv;
  logic signed [W-1:0] xv;
  logic signed [W-1:0] xt;
  logic signed [W-1:0] vlo;
  logic signed [W-1:0] xa;
  logic signed [W-1:0] tc;
  logic signed [W-1:0] ta;
  logic                s_neg;
  logic                ok_r;
  logic [PW-1:0]       vv;
  logic [PW-1:0]       ll;

  // Pose evaluation registers.
  logic signed [W-1:0] seg_p;
  logic signed [W-1:0] seg_v;
  logic signed [W-1:0] seg_acc;
  logic signed [W-1:0] dt;
  logic signed [W-1:0] av;
  logic signed [W-1:0] m2;
  logic                fin;

  // Shared multiplier.
  logic signed [W:0]    mul_a;
  logic signed [W:0]    mul_b;
  logic signed [PW-1:0] prod_q;

  // Shared divide / square root unit.
  tmp_pkg::ds_req_t ds_req;
  logic [PW-1:0]    ds_num;
  logic [W:0]       ds_den;
  logic             ds_done;
  logic [PW-1:0]    ds_quo;

  logic signed [W-1:0]  a_w;
  logic signed [W-1:0]  v_w;
  logic signed [XW-1:0] v_x;
  logic                 reject;
  logic signed [XW-1:0] dv_abs_x;
  logic signed [XW-1:0] xt_abs_x;
  logic                 flat_n;
  logic                 s_neg_n;
  logic signed [W-1:0]  vlo_n;
  logic signed [XW-1:0] cm_x;
  logic signed [XW-1:0] n_x;
  logic                 same_dir;
  logic signed [W-1:0]  m3;
  logic signed [W-1:0]  po;
  logic signed [W-1:0]  vo;
  logic                 in_take;
  logic                 out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    a_w      = {1'b0, max_acceleration};
    v_w      = {1'b0, max_velocity};
    v_x      = wx(v_w);
    reject   = (max_acceleration == '0) || (max_velocity == '0) ||
               (abs_x(wx(vi_r)) > v_x) || (abs_x(wx(vf_r)) > v_x);
    dv_abs_x = abs_x(wx(dv));
    xt_abs_x = abs_x(wx(xt));
    // With no displacement left, the ramp direction follows the velocity
    // change, and is positive when there is none.
    flat_n   = (xt == '0);
    s_neg_n  = flat_n ? dv[W-1] : xt[W-1];
    if (s_neg_n) vlo_n = (vf_r < vi_r) ? vf_r : vi_r;
    else vlo_n = (vf_r > vi_r) ? vf_r : vi_r;
    cm_x     = xt_abs_x - (wx(xa) <<< 1);
    n_x      = s_neg ? wx(vlo) - wx(cruise_vel) : wx(cruise_vel) - wx(vlo);
    same_dir = s_neg ? (dv < 0) : (dv > 0);
    m3       = mulq(prod_q);
    po       = sat_w(wx(seg_p) + wx(m2) + wx(half_sum(m3, '0)));
    vo       = sat_w(wx(seg_v) + wx(av));
  end

  // Operand selection for the multiplier; the product is always registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_XV_M: begin
        mul_a = e1(half_sum(vf_r, vi_r));
        mul_b = e1(tv);
      end
      S_VV_M: begin
        mul_a = e1(v_w);
        mul_b = e1(v_w);
      end
      S_LL_M: begin
        mul_a = e1(vlo);
        mul_b = e1(vlo);
      end
      S_AX_M: begin
        mul_a = e1(a_w);
        mul_b = xt_abs_x[W:0];
      end
      S_RP_M: begin
        mul_a = e1(half_sum(vi_r, cruise_vel));
        mul_b = e1(ramp_end_time);
      end
      S_CP_M: begin
        mul_a = e1(cruise_vel);
        mul_b = e1(tc);
      end
      S_AV_M: begin
        mul_a = e1(seg_acc);
        mul_b = e1(dt);
      end
      S_VD_M: begin
        mul_a = e1(seg_v);
        mul_b = e1(dt);
      end
      S_AD_M, S_AD: begin
        mul_a = e1(av);
        mul_b = e1(dt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
  end

  // Requests to the divide / square root unit.
  always_comb begin
    ds_req.start     = 1'b0;
    ds_req.sqrt_mode = 1'b0;
    ds_num           = '0;
    ds_den           = '0;
    unique case (state)
      S_TV: begin
        ds_req.start = (dv != '0);
        ds_num       = dv_abs_x[PW-1:0] << FRAC_BITS;
        ds_den       = {1'b0, a_w};
      end
      S_LL: begin
        // Distance to reach the velocity limit: (v*v - vlo*vlo) / (2*a).
        ds_req.start = 1'b1;
        ds_num       = vv - $unsigned(prod_q);
        ds_den       = {1'b0, max_acceleration, 1'b0};
      end
      S_CM: begin
        ds_req.start = (cm_x > 0);
        ds_num       = cm_x[PW-1:0] << FRAC_BITS;
        ds_den       = {1'b0, v_w};
      end
      S_AX: begin
        // Peak velocity of a triangular move: sqrt(vlo*vlo + a*|x|).
        ds_req.start     = 1'b1;
        ds_req.sqrt_mode = 1'b1;
        ds_num           = ll + $unsigned(prod_q);
      end
      S_TA: begin
        ds_req.start = (n_x > 0);
        ds_num       = n_x[PW-1:0] << FRAC_BITS;
        ds_den       = {1'b0, a_w};
      end
      default: begin
        ds_req.start = 1'b0;
      end
    endcase
  end

  tmp_divsqrt #(
    .WORD_BITS(WORD_BITS)
  ) u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (ds_req),
    .num  (ds_num),
    .den  (ds_den),
    .done (ds_done),
    .quo  (ds_quo)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity     <= '0;
      max_acceleration <= '0;
      tick_period      <= FRAC_BITS'(tmp_pkg::TICK_PERIOD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmp_pkg::REG_MAX_VELOCITY:     max_velocity     <= cfg_data[W-2:0];
        tmp_pkg::REG_MAX_ACCELERATION: max_acceleration <= cfg_data[W-2:0];
        tmp_pkg::REG_TICK_PERIOD:      tick_period      <= cfg_data[FRAC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: planning steps, then the three-multiply pose evaluation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      elapsed_time     <= '0;
      origin_pose_pos  <= '0;
      origin_pose_vel  <= '0;
      ramp_accel       <= '0;
      end_pose_pos     <= '0;
      end_pose_vel     <= '0;
      ramp_end_pos     <= '0;
      cruise_vel       <= '0;
      coast_end_pos    <= '0;
      ramp_end_time    <= '0;
      coast_end_time   <= '0;
      profile_end_time <= '0;
    end else begin
      // A result loaded this cycle keeps the output register full.
      if (out_valid && !out_stall && !(state == S_AD && out_free)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (op == tmp_pkg::OP_TICK) begin
              elapsed_time <= sat_t(wx(elapsed_time) +
                                    {{(XW-FRAC_BITS){1'b0}}, tick_period});
              ok_r         <= 1'b1;
              state        <= S_SEG;
            end else begin
              elapsed_time <= '0;
              pi_r         <= start_pos;
              vi_r         <= start_vel;
              pf_r         <= goal_pos;
              vf_r         <= goal_vel;
              state        <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (reject) begin
            // Hold still at the start position.
            ok_r             <= 1'b0;
            origin_pose_pos  <= pi_r;
            origin_pose_vel  <= '0;
            ramp_accel       <= '0;
            end_pose_pos     <= pi_r;
            end_pose_vel     <= '0;
            ramp_end_pos     <= pi_r;
            cruise_vel       <= '0;
            coast_end_pos    <= pi_r;
            ramp_end_time    <= '0;
            coast_end_time   <= '0;
            profile_end_time <= '0;
            state            <= S_SEG;
          end else begin
            ok_r  <= 1'b1;
            dv    <= sat_w(wx(vf_r) - wx(vi_r));
            state <= S_TV;
          end
        end
        S_TV: begin
          if (dv == '0) begin
            tv    <= '0;
            state <= S_XV_M;
          end else begin
            state <= S_TV_W;
          end
        end
        S_TV_W: begin
          if (ds_done) begin
            tv    <= satq(ds_quo);
            state <= S_XV_M;
          end
        end
        S_XV_M: state <= S_XV;
        S_XV: begin
          xv    <= mulq(prod_q);
          state <= S_XT;
        end
        S_XT: begin
          xt    <= sat_w(wx(sat_w(wx(pf_r) - wx(pi_r))) - wx(xv));
          state <= S_SIGN;
        end
        S_SIGN: begin
          s_neg <= s_neg_n;
          vlo   <= vlo_n;
          tc    <= '0;
          if (flat_n) begin
            cruise_vel <= vlo_n;
            state      <= S_TA;
          end else begin
            state <= S_VV_M;
          end
        end
        S_VV_M: state <= S_VV;
        S_VV: begin
          vv    <= $unsigned(prod_q);
          state <= S_LL_M;
        end
        S_LL_M: state <= S_LL;
        S_LL: begin
          ll    <= $unsigned(prod_q);
          state <= S_XA_W;
        end
        S_XA_W: begin
          if (ds_done) begin
            xa    <= satq(ds_quo);
            state <= S_CM;
          end
        end
        S_CM: begin
          // A coast phase exists when the move is longer than both ramps.
          state <= (cm_x > 0) ? S_TC_W : S_AX_M;
        end
        S_TC_W: begin
          if (ds_done) begin
            tc         <= satq(ds_quo);
            cruise_vel <= s_neg ? -v_w : v_w;
            state      <= S_TA;
          end
        end
        S_AX_M: state <= S_AX;
        S_AX:   state <= S_SQ_W;
        S_SQ_W: begin
          if (ds_done) begin
            cruise_vel <= s_neg ? -satq(ds_quo) : satq(ds_quo);
            state      <= S_TA;
          end
        end
        S_TA: begin
          if (n_x > 0) begin
            state <= S_TA_W;
          end else begin
            ta    <= '0;
            state <= S_AT;
          end
        end
        S_TA_W: begin
          if (ds_done) begin
            ta    <= satq(ds_quo);
            state <= S_AT;
          end
        end
        S_AT: begin
          // The velocity-matching time joins the first ramp when both push
          // the same way.
          ramp_end_time <= sat_t(wx(ta) + (same_dir ? wx(tv) : '0));
          state         <= S_RP_M;
        end
        S_RP_M: state <= S_RP;
        S_RP: begin
          ramp_end_pos   <= sat_w(wx(pi_r) + wx(mulq(prod_q)));
          coast_end_time <= sat_t(wx(ramp_end_time) + wx(tc));
          state          <= S_CP_M;
        end
        S_CP_M: state <= S_CP;
        S_CP: begin
          coast_end_pos    <= sat_w(wx(ramp_end_pos) + wx(mulq(prod_q)));
          profile_end_time <= sat_t((wx(ta) <<< 1) + wx(tc) + wx(tv));
          origin_pose_pos  <= pi_r;
          origin_pose_vel  <= vi_r;
          ramp_accel       <= s_neg ? -a_w : a_w;
          end_pose_pos     <= pf_r;
          end_pose_vel     <= vf_r;
          state            <= S_SEG;
        end
        S_SEG: begin
          // Pick the phase that holds the elapsed time.
          fin <= (elapsed_time > profile_end_time);
          if (elapsed_time > profile_end_time) begin
            seg_p   <= end_pose_pos;
            seg_v   <= end_pose_vel;
            seg_acc <= '0;
            dt      <= elapsed_time - profile_end_time;
          end else if (elapsed_time > coast_end_time) begin
            seg_p   <= coast_end_pos;
            seg_v   <= cruise_vel;
            seg_acc <= -ramp_accel;
            dt      <= elapsed_time - coast_end_time;
          end else if (elapsed_time > ramp_end_time) begin
            seg_p   <= ramp_end_pos;
            seg_v   <= cruise_vel;
            seg_acc <= '0;
            dt      <= elapsed_time - ramp_end_time;
          end else begin
            seg_p   <= origin_pose_pos;
            seg_v   <= origin_pose_vel;
            seg_acc <= ramp_accel;
            dt      <= elapsed_time;
          end
          state <= S_AV_M;
        end
        S_AV_M: state <= S_AV;
        S_AV: begin
          av    <= mulq(prod_q);
          state <= S_VD_M;
        end
        S_VD_M: state <= S_VD;
        S_VD: begin
          m2    <= mulq(prod_q);
          state <= S_AD_M;
        end
        S_AD_M: state <= S_AD;
        S_AD: begin
          // The multiplier keeps the same operands here, so the product
          // holds while the output register is still occupied.
          if (out_free) begin
            pose_pos  <= po;
            pose_vel  <= vo;
            pose_acc  <= seg_acc;
            finished  <= fin;
            accepted  <= ok_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/tmp_divsqrt.sv @@
// ----------------------------------------------------------------------------
// Shared divide / square root unit
// Restoring division at one quotient bit per cycle, or a digit-by-digit floor
// square root at one root bit per cycle, on unsigned operands.
// ----------------------------------------------------------------------------
module tmp_divsqrt #(
  parameter int WORD_BITS = tmp_pkg::WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tmp_pkg::ds_req_t         req,
  input  logic [2*WORD_BITS+1:0]   num,
  input  logic [WORD_BITS:0]       den,
  output logic                     done,
  output logic [2*WORD_BITS+1:0]   quo
);

  localparam int NW = 2 * WORD_BITS + 2;
  localparam int DW = WORD_BITS + 1;
  localparam int RW = WORD_BITS + 4;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic          mode;
  logic [CW-1:0] cnt;
  logic [NW-1:0] num_sh;
  logic [RW-1:0] rem;
  logic [DW-1:0] den_r;

  logic [RW-1:0] d_trial;
  logic          d_ge;
  logic [RW-1:0] s_trial;
  logic [RW-1:0] s_test;
  logic          s_ge;

  always_comb begin
    d_trial = {rem[RW-2:0], num_sh[NW-1]};
    d_ge    = d_trial >= {{(RW-DW){1'b0}}, den_r};
    s_trial = {rem[RW-3:0], num_sh[NW-1:NW-2]};
    s_test  = {quo[RW-3:0], 2'b01};
    s_ge    = s_trial >= s_test;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.sqrt_mode ? CW'(NW / 2) : CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode   <= req.sqrt_mode;
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      if (mode) begin
        num_sh <= {num_sh[NW-3:0], 2'b00};
        rem    <= s_ge ? s_trial - s_test : s_trial;
        quo    <= {quo[NW-2:0], s_ge};
      end else begin
        num_sh <= {num_sh[NW-2:0], 1'b0};
        rem    <= d_ge ? d_trial - {{(RW-DW){1'b0}}, den_r} : d_trial;
        quo    <= {quo[NW-2:0], d_ge};
      end
    end
  end

endmodule
